// ----- rtl/core/ssfr_pkg.sv -----
// shared types, constants and codes of the stereo sample frame receiver
package ssfr_pkg;

    // sample pairs per bank
    localparam int MAX_SAMPLES  = 256;
    localparam int BANK_AW      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int RAM_AW       = BANK_AW + 1;
    localparam int BYTE_LIMIT   = 4 * MAX_SAMPLES;
    localparam int BC_W         = $clog2(BYTE_LIMIT + 2);

    // field widths
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 8;
    localparam int FS_W         = 9;
    localparam int CHUNK_W      = 5;
    localparam int SAMPLE_W     = 10;
    localparam int HELD_W       = 15;
    localparam int WORD_W       = 2 * SAMPLE_W;
    localparam int STATUS_W     = 2;

    // stream payload widths
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SAMPLES = 2'd2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'b0111_1000;
    localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'b0011_0000;
    localparam logic [FS_W-1:0]   FRAME_SAMPLES_RST = 9'd256;
    localparam logic [BYTE_W-1:0] CHAR_BASE         = 8'd65;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

    // command queue
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rd_ok;
        logic [RAM_AW-1:0]   addr;
    } t_cmd;

    typedef struct packed {
        logic              nonempty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_ram_wr;

endpackage

// ----- rtl/core/ssfr_ram.sv -----
// generic single write port ram with registered read
module ssfr_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ssfr_front.sv -----
// front end: takes items, runs the frame hunter and writes decoded pairs
module ssfr_front
    import ssfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_op,
    input  logic [S_TDATA_W-1:0]  i_data,
    input  t_q_status             i_q_stat,
    output logic                  o_ready,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output t_ram_wr               o_wr
);

    localparam int CMP_W = (BC_W > FS_W + 2) ? BC_W : FS_W + 2;

    typedef enum logic {ST_HUNT, ST_FRAME} t_frame_state;

    t_frame_state       r_state, n_state;
    logic [BC_W-1:0]    r_bc, n_bc;
    logic [HELD_W-1:0]  r_held, n_held;
    logic               r_commit, n_commit;
    logic               r_bvalid, n_bvalid;
    logic [BYTE_W-1:0]  r_start, r_end;
    logic [FS_W-1:0]    r_fs;

    logic               accept;
    logic [BYTE_W-1:0]  ch;
    logic [IDX_W-1:0]   ridx;
    logic [BYTE_W-1:0]  ch_off;
    logic [CHUNK_W-1:0] chunk;
    logic [1:0]         pos;
    logic               len_ok;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign ch      = i_data[BYTE_W-1:0];
    assign ridx    = i_data[BYTE_W +: IDX_W];
    assign ch_off  = ch - CHAR_BASE;
    assign chunk   = ch_off[CHUNK_W-1:0];
    assign pos     = r_bc[1:0];
    assign len_ok  = (r_fs != '0) && (32'(r_fs) <= MAX_SAMPLES)
                     && (CMP_W'(r_bc) == CMP_W'({r_fs, 2'b00}));

    always_comb begin
        n_state      = r_state;
        n_bc         = r_bc;
        n_held       = r_held;
        n_commit     = r_commit;
        n_bvalid     = r_bvalid;
        o_push       = accept;
        o_cmd.status = STATUS_NONE;
        o_cmd.rd_ok  = 1'b0;
        o_cmd.addr   = {r_commit, BANK_AW'(ridx)};
        o_wr.en      = 1'b0;
        o_wr.addr    = {~r_commit, BANK_AW'(r_bc >> 2)};
        o_wr.data    = {chunk, r_held[14:10], r_held[9:0]};
        if (accept) begin
            if (i_op == OP_READ) begin
                o_cmd.rd_ok = r_bvalid && (32'(ridx) < MAX_SAMPLES);
            end else begin
                case (r_state)
                    ST_HUNT: begin
                        if (ch == r_start) begin
                            n_state = ST_FRAME;
                            n_bc    = '0;
                            n_held  = '0;
                        end
                    end
                    ST_FRAME: begin
                        if (ch == r_end) begin
                            n_state = ST_HUNT;
                            if (len_ok) begin
                                n_commit     = ~r_commit;
                                n_bvalid     = 1'b1;
                                o_cmd.status = STATUS_OK;
                            end else begin
                                o_cmd.status = STATUS_LEN_ERR;
                            end
                        end else begin
                            // bytes past the limit are not stored; the count stops one past it
                            if (32'(r_bc) < BYTE_LIMIT) begin
                                case (pos)
                                    2'd0:    n_held[4:0]   = chunk;
                                    2'd1:    n_held[9:5]   = chunk;
                                    2'd2:    n_held[14:10] = chunk;
                                    default: o_wr.en       = 1'b1;
                                endcase
                            end
                            if (32'(r_bc) <= BYTE_LIMIT) begin
                                n_bc = r_bc + BC_W'(1);
                            end
                        end
                    end
                    default: n_state = ST_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_bc     <= '0;
            r_held   <= '0;
            r_commit <= 1'b0;
            r_bvalid <= 1'b0;
            r_start  <= START_MARKER_RST;
            r_end    <= END_MARKER_RST;
            r_fs     <= FRAME_SAMPLES_RST;
        end else begin
            r_state  <= n_state;
            r_bc     <= n_bc;
            r_held   <= n_held;
            r_commit <= n_commit;
            r_bvalid <= n_bvalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_MARKER:  r_start <= i_cfg_data[BYTE_W-1:0];
                    CFG_END_MARKER:    r_end   <= i_cfg_data[BYTE_W-1:0];
                    CFG_FRAME_SAMPLES: r_fs    <= i_cfg_data[FS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/ssfr_queue.sv -----
// short command queue between front and back end
module ssfr_queue
    import ssfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_stat
);

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_stat.count    = r_count;
    assign o_stat.full     = (32'(r_count) == QUEUE_DEPTH);
    assign o_stat.nonempty = (r_count != '0);
    assign do_push         = i_push && !o_stat.full;
    assign do_pop          = i_pop && o_stat.nonempty;
    assign o_head          = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/ssfr_back.sv -----
// back end: reads committed pairs and drives the result register
module ssfr_back
    import ssfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_head,
    input  t_q_status            i_q_stat,
    input  logic [WORD_W-1:0]    i_rdata,
    input  logic                 i_ready,
    output logic                 o_pop,
    output logic                 o_re,
    output logic [RAM_AW-1:0]    o_raddr,
    output logic                 o_valid,
    output logic [M_TDATA_W-1:0] o_data
);

    logic                 r_s1_valid;
    t_cmd                 r_s1_cmd;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 s1_adv;
    logic [WORD_W-1:0]    word;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_pop   = i_q_stat.nonempty && (!r_s1_valid || s1_adv);
    assign o_re    = o_pop;
    assign o_raddr = i_head.addr;
    assign word    = r_s1_cmd.rd_ok ? i_rdata : '0;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_head;
        end
        if (s1_adv) begin
            r_out_data <= {(M_TDATA_W - STATUS_W - WORD_W)'(0), word, r_s1_cmd.status};
        end
    end

endmodule

// ----- rtl/core/stereo_sample_frame_receiver.sv -----
// top level of the stereo sample frame receiver
//
// slave stream: one item per transfer; s_axis_tuser selects a received
// serial byte (0) or a read of the committed sample pair (1). the byte and
// the read index travel in s_axis_tdata.
// master stream: exactly one result per item, in item order: frame status
// and, for reads, the left and right samples of the committed bank.
// configuration: i_cfg_we with i_cfg_index selects start marker, end marker
// or frame length; the user writes only while the block is idle, unchecked.
// throughput: one item per cycle while the queue is not full; a new item is
// taken while earlier ones are still in the queue or the result register.
// path: the front end settles state in the accepting cycle; the item then
// passes the command queue, the bank ram read port and the result register
// in that order, and may wait in any of them while the master side stalls.
// reset: synchronous, clears the frame hunter, bank selection, queue and
// output valid, and restores the register defaults; the banks hold no
// defined data until a frame has been written.
// stall: a stalled master side fills the four-entry queue, then
// s_axis_tready drops until results drain.
module stereo_sample_frame_receiver
    import ssfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rx_byte [7:0], read_index [15:8]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // frame_status [1:0], left_sample [11:2], right_sample [21:12], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    t_cmd              w_cmd;
    t_cmd              w_head;
    t_q_status         w_qstat;
    t_ram_wr           w_wr;
    logic              w_push;
    logic              w_pop;
    logic              w_re;
    logic [RAM_AW-1:0] w_raddr;
    logic [WORD_W-1:0] w_rdata;

    // front end owns the frame state and the bank swap; a read is resolved
    // to a bank address at transfer, and the queue is too short for that
    // bank to be rewritten before the back end reads it
    ssfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_q_stat    (w_qstat),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_cmd       (w_cmd),
        .o_wr        (w_wr)
    );

    ssfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // both banks in one ram, bank select in the top address bit
    ssfr_ram #(
        .WIDTH  (WORD_W),
        .ADDR_W (RAM_AW)
    ) u_banks (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ssfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_qstat),
        .i_rdata  (w_rdata),
        .i_ready  (m_axis_tready),
        .o_pop    (w_pop),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata)
    );

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_qstat.count) <= QUEUE_DEPTH)
        else $error("command queue overfilled");

    // a completed frame never carries sample data
    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != STATUS_NONE))
        |-> (m_axis_tdata[STATUS_W +: WORD_W] == '0))
        else $error("frame status result with nonzero samples");

    // no result in the first cycle out of reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
